// File: rtl/core/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// assertion on the default clock and reset of the block
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/cdlr_pkg.sv
// types, constants and helper functions of the counter dump link receiver
package cdlr_pkg;

  localparam int INDEX_BITS = 16;

  // positions the index width can reach, clipped to the 16-bit capacity range
  localparam logic [15:0] POS_SPAN = (INDEX_BITS >= 16) ? 16'hFFFF : 16'(1 << INDEX_BITS);

  typedef enum logic [2:0] {
    MODE_STATS   = 3'd0,
    MODE_DUMP    = 3'd1,
    MODE_STATUS  = 3'd2,
    MODE_ABORT   = 3'd3,
    MODE_TEST    = 3'd4,
    MODE_RX      = 3'd5,
    MODE_TIMEOUT = 3'd6,
    MODE_CLEAR   = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HDR    = 3'd1,
    PH_SIZE   = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4,
    PH_STATUS = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_STATS  = 2'd0,
    KIND_DUMP   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_CAPACITY = 2'd0,
    REG_RETRY    = 2'd1
  } reg_e;

  // command codes, low six bits of a command byte
  localparam logic [5:0] CMD_DUMP   = 6'o10;
  localparam logic [5:0] CMD_STATUS = 6'o20;
  localparam logic [5:0] CMD_TEST   = 6'o30;
  localparam logic [5:0] CMD_NAK    = 6'o33;
  localparam logic [5:0] CMD_ACK    = 6'o34;
  localparam logic [5:0] CMD_ABORT  = 6'o37;

  localparam logic [7:0] CHR_STATS = 8'h23;  // '#'
  localparam logic [7:0] CHR_FRAME = 8'h3A;  // ':'
  localparam logic [7:0] CHR_END   = 8'h2E;  // '.'

  localparam logic [8:0] FULL_FRAME = 9'h100;

  // flag bits
  localparam logic [3:0] F_HDR  = 4'b0001;
  localparam logic [3:0] F_OVER = 4'b0010;
  localparam logic [3:0] F_SUM  = 4'b0100;
  localparam logic [3:0] F_TIME = 4'b1000;

  localparam logic [15:0] CAP_RESET   = 16'hFFFF;
  localparam logic [3:0]  RETRY_RESET = 4'd10;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] counter;
    logic [1:0] unit;
    logic [7:0] rx_data;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        flush_port;
    logic        wr_valid;
    logic [15:0] wr_index;
    logic [7:0]  wr_data;
    logic        done_res;
    logic        ok;
    logic [15:0] result_count;
    logic [3:0]  status_flags;
    logic [7:0]  status_reply;
  } res_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic [3:0]  retry_limit;
  } ctrl_t;

  typedef struct packed {
    phase_e                  phase;
    kind_e                   kind;
    logic [1:0]              addr;
    logic [8:0]              remaining;
    logic [7:0]              sum;
    logic [15:0]             base;
    logic [15:0]             wpos;
    logic [3:0]              retries;
    logic [3:0]              flags;
  } state_t;

  // counter number to code within its unit (0..5)
  function automatic logic [2:0] counter_code(input logic [3:0] c);
    logic [3:0] r;
    if (c >= 4'd12) begin
      r = c - 4'd12;
    end else if (c >= 4'd6) begin
      r = c - 4'd6;
    end else begin
      r = c;
    end
    return r[2:0];
  endfunction

  function automatic logic [1:0] unit_addr(input logic [1:0] u);
    logic [1:0] a;
    case (u)
      2'd0:    a = 2'd1;
      2'd1:    a = 2'd2;
      default: a = 2'd3;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/cdlr_chan_if.sv
// valid/ready channel carrying one payload word
interface cdlr_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cdlr_step.sv
// next-state and result logic for one input word
module cdlr_step (
  input  cdlr_pkg::state_t st_i,
  input  cdlr_pkg::in_t    item_i,
  input  cdlr_pkg::ctrl_t  ctrl_i,
  output cdlr_pkg::state_t st_o,
  output cdlr_pkg::res_t   res_o
);
  import cdlr_pkg::*;

  state_t     st;
  res_t       r;
  logic [2:0] code;
  logic [1:0] uaddr;
  logic [3:0] retries_inc;

  assign code        = counter_code(item_i.counter);
  assign uaddr       = unit_addr(item_i.unit);
  assign retries_inc = st_i.retries + 4'd1;

  always_comb begin
    st = st_i;
    r  = '0;
    case (mode_e'(item_i.mode))
      MODE_STATS, MODE_DUMP: begin
        st.addr = (item_i.counter >= 4'd6) ? 2'd2 : 2'd1;
        r.tx_valid = 1'b1;
        if (mode_e'(item_i.mode) == MODE_STATS) begin
          st.kind = KIND_STATS;
          r.tx_byte = {st.addr, 3'd0, code};
        end else begin
          st.kind = KIND_DUMP;
          r.tx_byte = {st.addr, CMD_DUMP | {3'd0, code}};
        end
        st.base    = '0;
        st.wpos    = '0;
        st.retries = '0;
        if (st_i.flags != '0) begin
          r.done_res = 1'b1;
          st.phase   = PH_IDLE;
        end else begin
          st.phase = PH_HDR;
        end
      end
      MODE_STATUS: begin
        st.kind = KIND_STATUS;
        st.addr = uaddr;
        // units beyond the second get no command
        if (item_i.unit < 2'd2) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = {uaddr, CMD_STATUS};
        end
        if (st_i.flags != '0) begin
          r.done_res = 1'b1;
          st.phase   = PH_IDLE;
        end else begin
          st.phase = PH_STATUS;
        end
      end
      MODE_ABORT: begin
        st.phase     = PH_IDLE;
        r.flush_port = 1'b1;
        r.tx_valid   = 1'b1;
        r.tx_byte    = {uaddr, CMD_ABORT};
      end
      MODE_TEST: begin
        st.phase   = PH_IDLE;
        r.tx_valid = 1'b1;
        r.tx_byte  = {uaddr, CMD_TEST};
      end
      MODE_RX: begin
        case (st_i.phase)
          PH_IDLE: begin
          end
          PH_HDR: begin
            if ((st_i.kind == KIND_STATS && item_i.rx_data == CHR_STATS) ||
                (st_i.kind == KIND_DUMP && item_i.rx_data == CHR_FRAME)) begin
              st.phase = PH_SIZE;
            end else if (st_i.kind == KIND_DUMP && item_i.rx_data == CHR_END) begin
              r.done_res     = 1'b1;
              r.ok           = 1'b1;
              r.result_count = st_i.base;
              st.phase       = PH_IDLE;
            end else begin
              st.flags   = st_i.flags | F_HDR;
              r.done_res = 1'b1;
              st.phase   = PH_IDLE;
            end
          end
          PH_SIZE: begin
            st.remaining = (item_i.rx_data == '0) ? FULL_FRAME : {1'b0, item_i.rx_data};
            st.sum       = '0;
            st.wpos      = st_i.base;
            st.phase     = PH_DATA;
          end
          PH_DATA: begin
            if (st_i.wpos >= ctrl_i.capacity || st_i.wpos >= POS_SPAN) begin
              st.flags   = st_i.flags | F_OVER;
              r.done_res = 1'b1;
              st.phase   = PH_IDLE;
            end else begin
              r.wr_valid   = 1'b1;
              r.wr_index   = st_i.wpos;
              r.wr_data    = item_i.rx_data;
              st.sum       = st_i.sum + item_i.rx_data;
              st.wpos      = st_i.wpos + 16'd1;
              st.remaining = st_i.remaining - 9'd1;
              if (st.remaining == '0) begin
                st.phase = PH_SUM;
              end
            end
          end
          PH_SUM: begin
            if (st_i.kind == KIND_STATS) begin
              // a stats frame still completes with a bad sum, only flagged
              if (item_i.rx_data != st_i.sum) begin
                st.flags = st_i.flags | F_SUM;
              end
              r.done_res     = 1'b1;
              r.ok           = 1'b1;
              r.result_count = st_i.wpos;
              st.phase       = PH_IDLE;
            end else if (item_i.rx_data != st_i.sum) begin
              st.retries = retries_inc;
              r.tx_valid = 1'b1;
              if (retries_inc == ctrl_i.retry_limit) begin
                r.flush_port = 1'b1;
                r.tx_byte    = {st_i.addr, CMD_ABORT};
                st.flags     = st_i.flags | F_SUM;
                r.done_res   = 1'b1;
                st.phase     = PH_IDLE;
              end else begin
                r.tx_byte = {st_i.addr, CMD_NAK};
                st.wpos   = st_i.base;
                if (st_i.flags != '0) begin
                  r.done_res = 1'b1;
                  st.phase   = PH_IDLE;
                end else begin
                  st.phase = PH_HDR;
                end
              end
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte  = {st_i.addr, CMD_ACK};
              st.base    = st_i.wpos;
              st.retries = '0;
              if (st_i.flags != '0) begin
                r.done_res = 1'b1;
                st.phase   = PH_IDLE;
              end else begin
                st.phase = PH_HDR;
              end
            end
          end
          PH_STATUS: begin
            r.done_res     = 1'b1;
            r.ok           = 1'b1;
            r.status_reply = item_i.rx_data;
            st.phase       = PH_IDLE;
          end
          default: begin
            st.phase = PH_IDLE;
          end
        endcase
      end
      MODE_TIMEOUT: begin
        if (st_i.phase != PH_IDLE) begin
          st.flags   = st_i.flags | F_TIME;
          r.done_res = 1'b1;
          st.phase   = PH_IDLE;
        end
      end
      MODE_CLEAR: begin
        st.flags = '0;
      end
      default: begin
      end
    endcase
    r.status_flags = st.flags;
    st_o  = st;
    res_o = r;
  end

endmodule

// File: rtl/core/counter_dump_link_receiver.sv
// throughput: one word per cycle while the result register is free or taken; input register, then one step of logic
//   against the request state into the result register
// ready drops only while the result register is full and not taken
// reset clears all state and flags, capacity to 65535 and retry limit to 10
module counter_dump_link_receiver (
  input logic             clk_i,
  input logic             rst_ni,
  cdlr_chan_if.sink       in_i,
  cdlr_chan_if.source     out_o,
  cdlr_chan_if.sink       cfg_i
);
  import cdlr_pkg::*;

  logic   in_vld_q;
  in_t    in_q;
  logic   out_vld_q;
  res_t   out_q;
  ctrl_t  ctrl_q;
  state_t st_q;
  state_t st_d;
  res_t   res_d;
  logic   step_en;
  logic   in_take;

  // the step fires whenever the input register holds a word and the result register can take it
  assign step_en = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready  = !in_vld_q || step_en;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  cdlr_step u_step (
    .st_i   (st_q),
    .item_i (in_q),
    .ctrl_i (ctrl_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
      ctrl_q    <= '{capacity: CAP_RESET, retry_limit: RETRY_RESET};
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (step_en) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (reg_e'(cfg_i.data.index))
          REG_CAPACITY: ctrl_q.capacity    <= cfg_i.data.data;
          REG_RETRY:    ctrl_q.retry_limit <= cfg_i.data.data[3:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.data;
    end
    if (step_en) begin
      out_q <= res_d;
    end
  end

  `include "assert_macros.svh"

  `ASSERT_DEF(a_flags_sticky, (st_q.flags & ~st_d.flags) != '0 && step_en |-> mode_e'(in_q.mode) == MODE_CLEAR, "flags dropped without clear")
  `ASSERT_DEF(a_done_idle, step_en && res_d.done_res |=> st_q.phase == PH_IDLE, "request not idle after done")
  `ASSERT_DEF(a_wr_not_done, out_vld_q && out_q.wr_valid |-> !out_q.done_res, "store word also marked done")
  `ASSERT_DEF(a_in_hold, in_vld_q && !step_en |=> in_vld_q && $stable(in_q), "held input word lost")

endmodule
